// ----- hdl/ffb_pkg.sv -----
// ----------------------------------------------------------------------------
// ffb_pkg
// Shared types and constants of the frame FIFO with batch pop.
// ----------------------------------------------------------------------------
package ffb_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int HANDLE_W = 32;
  localparam int CNT_W    = 7;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_EOF    = 3'd2,
    FN_CANCEL = 3'd3,
    FN_FLUSH  = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_CANCEL = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BAD    = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

endpackage

// ----- hdl/ffb_slot_ram.sv -----
// ----------------------------------------------------------------------------
// ffb_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffb_slot_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ffb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffb_ctrl
// Command sequencer: pointers, fill count, flags and the per-frame pop step.
// ----------------------------------------------------------------------------
module ffb_ctrl #(
  parameter int DEPTH     = 64,
  parameter int MAX_BATCH = 64,
  parameter int HB        = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffb_pkg::FUNC_W-1:0]    func,
  input  logic [HB-1:0]                 frame_handle,
  input  logic                          ends_track,
  input  logic [ffb_pkg::CNT_W-1:0]     batch_limit,
  input  logic                          cfg_we,
  input  logic [ffb_pkg::CNT_W-1:0]     cfg_wdata,
  output logic                          ram_we,
  output logic [$clog2(DEPTH)-1:0]      ram_waddr,
  output logic [HB:0]                   ram_wdata,
  output logic [$clog2(DEPTH)-1:0]      ram_raddr,
  input  logic [HB:0]                   ram_rdata,
  output logic                          done,
  output logic [ffb_pkg::STATUS_W-1:0]  status,
  output logic [ffb_pkg::HANDLE_W-1:0]  out_frame,
  output logic                          frame_valid,
  output logic                          run_end,
  output logic [ffb_pkg::CNT_W-1:0]     batch_count,
  output logic                          track_done,
  output logic [ffb_pkg::CNT_W-1:0]     fill_level,
  output logic                          eof_seen,
  output logic                          is_cancelled
);

  import ffb_pkg::*;

  localparam int PW      = $clog2(DEPTH);
  localparam int EW      = (PW > CNT_W ? PW : CNT_W) + 1;
  localparam int CAP_MAX = DEPTH < 127 ? DEPTH : 127;

  state_t state, state_next;

  logic [CNT_W-1:0] queue_capacity;
  logic [CNT_W-1:0] cap_eff;
  logic [PW-1:0]    write_ptr, write_ptr_next;
  logic [PW-1:0]    read_ptr, read_ptr_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic             eof_flag, eof_flag_next;
  logic             cancel_flag, cancel_flag_next;
  logic [CNT_W-1:0] limit, limit_next;
  logic [CNT_W-1:0] popped, popped_next;

  logic                done_next;
  logic [STATUS_W-1:0] status_next;
  logic [HANDLE_W-1:0] out_frame_next;
  logic                frame_valid_next;
  logic                run_end_next;
  logic [CNT_W-1:0]    batch_count_next;
  logic                track_done_next;

  logic             accept;
  func_t            fn;
  logic [CNT_W-1:0] limit_eff;
  logic [CNT_W-1:0] pop_cnt;
  logic             pop_tag;
  logic             pop_last;
  logic             pop_go;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p,
                                            input logic [CNT_W-1:0] c);
    logic [EW-1:0] s;
    s = EW'(p) + EW'(1);
    return (s >= EW'(c)) ? '0 : s[PW-1:0];
  endfunction

  assign accept = start && (state == S_IDLE);
  assign busy   = (state == S_POP);
  assign fn     = func_t'(func);

  always_comb begin
    if (queue_capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(queue_capacity) > CAP_MAX) begin
      cap_eff = CNT_W'(CAP_MAX);
    end else begin
      cap_eff = queue_capacity;
    end
  end

  assign limit_eff = (int'(batch_limit) > MAX_BATCH) ? CNT_W'(MAX_BATCH) : batch_limit;

  // one frame per cycle out of the registered read port
  assign pop_cnt  = popped + CNT_W'(1);
  assign pop_tag  = ram_rdata[HB];
  assign pop_last = pop_tag || (pop_cnt >= limit) || (held_count == CNT_W'(1));

  assign pop_go = accept && (fn == FN_POP) && (batch_limit != '0) && !cancel_flag &&
                  (held_count != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (pop_go) state_next = S_POP;
      S_POP:  if (pop_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    write_ptr_next   = write_ptr;
    read_ptr_next    = read_ptr;
    held_count_next  = held_count;
    eof_flag_next    = eof_flag;
    cancel_flag_next = cancel_flag;
    limit_next       = limit;
    popped_next      = popped;
    ram_we           = 1'b0;
    ram_waddr        = write_ptr;
    ram_wdata        = {ends_track, frame_handle};
    ram_raddr        = read_ptr;
    done_next        = 1'b0;
    status_next      = ST_OK;
    out_frame_next   = '0;
    frame_valid_next = 1'b0;
    run_end_next     = 1'b1;
    batch_count_next = '0;
    track_done_next  = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          unique case (fn)
            FN_PUSH: begin
              if (cancel_flag) begin
                status_next = ST_CANCEL;
              end else if (held_count >= cap_eff) begin
                status_next = ST_FULL;
              end else begin
                ram_we          = 1'b1;
                write_ptr_next  = ptr_inc(write_ptr, cap_eff);
                held_count_next = held_count + CNT_W'(1);
              end
            end
            FN_POP: begin
              if (batch_limit == '0) begin
                status_next = ST_BAD;
              end else if (cancel_flag) begin
                status_next = ST_CANCEL;
              end else if (held_count == '0) begin
                status_next = eof_flag ? ST_OK : ST_EMPTY;
              end else begin
                // results come from the pop steps
                done_next   = 1'b0;
                limit_next  = limit_eff;
                popped_next = '0;
              end
            end
            FN_EOF:    eof_flag_next = 1'b1;
            FN_CANCEL: cancel_flag_next = 1'b1;
            FN_FLUSH: begin
              write_ptr_next   = '0;
              read_ptr_next    = '0;
              held_count_next  = '0;
              eof_flag_next    = 1'b0;
              cancel_flag_next = 1'b0;
            end
            default: status_next = ST_BAD;
          endcase
        end
      end
      S_POP: begin
        // read ahead so the next slot is ready on the following cycle
        ram_raddr        = ptr_inc(read_ptr, cap_eff);
        read_ptr_next    = ptr_inc(read_ptr, cap_eff);
        held_count_next  = held_count - CNT_W'(1);
        popped_next      = pop_cnt;
        done_next        = 1'b1;
        out_frame_next   = HANDLE_W'(ram_rdata[HB-1:0]);
        frame_valid_next = 1'b1;
        run_end_next     = pop_last;
        batch_count_next = pop_cnt;
        track_done_next  = pop_tag;
      end
      default: ;
    endcase

    // capacity write empties the queue, flags stay
    if (cfg_we) begin
      write_ptr_next  = '0;
      read_ptr_next   = '0;
      held_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      queue_capacity <= CAP_RESET;
      write_ptr      <= '0;
      read_ptr       <= '0;
      held_count     <= '0;
      eof_flag       <= 1'b0;
      cancel_flag    <= 1'b0;
      done           <= 1'b0;
    end else begin
      state       <= state_next;
      write_ptr   <= write_ptr_next;
      read_ptr    <= read_ptr_next;
      held_count  <= held_count_next;
      eof_flag    <= eof_flag_next;
      cancel_flag <= cancel_flag_next;
      done        <= done_next;
      if (cfg_we) begin
        queue_capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    limit        <= limit_next;
    popped       <= popped_next;
    status       <= status_next;
    out_frame    <= out_frame_next;
    frame_valid  <= frame_valid_next;
    run_end      <= run_end_next;
    batch_count  <= batch_count_next;
    track_done   <= track_done_next;
    fill_level   <= held_count_next;
    eof_seen     <= eof_flag_next;
    is_cancelled <= cancel_flag_next;
  end

endmodule

// ----- hdl/frame_fifo_with_track_batch_pop_unit.sv -----
// ----------------------------------------------------------------------------
// frame_fifo_with_track_batch_pop_unit
// Ring FIFO of frame handles with end-of-track tags and batch pop.
// ----------------------------------------------------------------------------
// Commands enter on start with func and their operands; a command is taken
// at a clock edge where start is high and busy is low. Every result beat is
// shown for one cycle with done high; the receiver cannot stall it.
// Push, eof, cancel, flush and every pop that returns no frame answer with
// one beat in the cycle after the command is taken, and the next command
// can be taken right away. A pop of n frames keeps busy high while it
// steps through its frames and sends one beat per frame on consecutive
// cycles, the first in the cycle after a single-beat answer would show,
// because the slot read is registered; the last beat shows in the cycle
// at whose end the next command can be taken. The pace is one slot-store
// read per cycle through the sequencer's step unit, with the next slot
// read ahead. The batch stops early after a frame tagged as end of track.
// cfg_we writes the capacity register (its value is used clamped to
// 1..min(DEPTH, 127)) and empties the queue; write it only while idle.
// Reset empties the queue, clears both flags and sets capacity to 64; the
// slot store itself is not cleared.
// ----------------------------------------------------------------------------
module frame_fifo_with_track_batch_pop_unit #(
  parameter int DEPTH       = 64,
  parameter int MAX_BATCH   = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ffb_pkg::FUNC_W-1:0]    func,
  input  logic [ffb_pkg::HANDLE_W-1:0]  frame_handle,
  input  logic                          ends_track,
  input  logic [ffb_pkg::CNT_W-1:0]     batch_limit,
  input  logic                          cfg_we,
  input  logic [ffb_pkg::CNT_W-1:0]     cfg_wdata,
  output logic                          done,
  output logic [ffb_pkg::STATUS_W-1:0]  status,
  output logic [ffb_pkg::HANDLE_W-1:0]  out_frame,
  output logic                          frame_valid,
  output logic                          run_end,
  output logic [ffb_pkg::CNT_W-1:0]     batch_count,
  output logic                          track_done,
  output logic [ffb_pkg::CNT_W-1:0]     fill_level,
  output logic                          eof_seen,
  output logic                          is_cancelled
);

  import ffb_pkg::*;

  localparam int HB = HANDLE_BITS < HANDLE_W ? HANDLE_BITS : HANDLE_W;
  localparam int PW = $clog2(DEPTH);

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [HB:0]   ram_wdata;
  logic [PW-1:0] ram_raddr;
  logic [HB:0]   ram_rdata;

  ffb_slot_ram #(
    .DEPTH (DEPTH),
    .WIDTH (HB + 1)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BATCH (MAX_BATCH),
    .HB        (HB)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .frame_handle (frame_handle[HB-1:0]),
    .ends_track   (ends_track),
    .batch_limit  (batch_limit),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .done         (done),
    .status       (status),
    .out_frame    (out_frame),
    .frame_valid  (frame_valid),
    .run_end      (run_end),
    .batch_count  (batch_count),
    .track_done   (track_done),
    .fill_level   (fill_level),
    .eof_seen     (eof_seen),
    .is_cancelled (is_cancelled)
  );

endmodule
